@@ hw/rtl/stream_find_replace_macros.svh @@
// ---------------------------------------------------------------------------
// Stream find-and-replace assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef STREAM_FIND_REPLACE_MACROS_SVH
`define STREAM_FIND_REPLACE_MACROS_SVH

// Check a property at every clock edge outside reset.
`define SFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define SFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/sfr_pkg.sv @@
// ---------------------------------------------------------------------------
// Stream find-and-replace package
// Register indexes and the command passed from classifier to serializer.
// ---------------------------------------------------------------------------
package sfr_pkg;

  localparam int unsigned CNT_W = 4;

  typedef enum logic [1:0] {
    CFG_SEARCH_WORD = 2'd0,
    CFG_SEARCH_LEN  = 2'd1,
    CFG_REPL_WORD   = 2'd2,
    CFG_REPL_LEN    = 2'd3
  } sfr_cfg_e;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             last;
  } sfr_cmd_t;

endpackage

@@ hw/rtl/sfr_front.sv @@
// ---------------------------------------------------------------------------
// Stream find-and-replace classifier
// Holds configuration and the match window, turns each input word into a
// command: a byte vector, a count of bytes to send and an end mark.
// ---------------------------------------------------------------------------
`include "stream_find_replace_macros.svh"

module sfr_front
  import sfr_pkg::*;
#(
  parameter int unsigned MAX_WORD_BYTES = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [63:0]                 cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  in_byte_i,
  input  logic                        in_last_i,
  input  logic                        q_full_i,
  output logic                        push_o,
  output sfr_cmd_t                    cmd_o,
  output logic [8*MAX_WORD_BYTES-1:0] cmd_data_o
);

  localparam int unsigned IDX_W = (MAX_WORD_BYTES > 1) ? $clog2(MAX_WORD_BYTES) : 1;
  localparam logic [CNT_W-1:0] MAX_L = CNT_W'(MAX_WORD_BYTES);

  logic [63:0]      search_word_q;
  logic [3:0]       search_len_q;
  logic [63:0]      repl_word_q;
  logic [3:0]       repl_len_q;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [7:0]       win_q [MAX_WORD_BYTES];
  logic [7:0]       win_d [MAX_WORD_BYTES];
  logic [7:0]       win_new [MAX_WORD_BYTES];
  logic [8*MAX_WORD_BYTES-1:0] win_flat;
  logic [MAX_WORD_BYTES-1:0]   eq;

  logic [CNT_W-1:0] len_eff, repl_eff;
  logic             accept, full, match;

  assign accept     = in_valid_i && !q_full_i;
  assign in_ready_o = !q_full_i;

  always_comb begin
    if (search_len_q == 4'd0) begin
      len_eff = CNT_W'(1);
    end else if (search_len_q > MAX_L) begin
      len_eff = MAX_L;
    end else begin
      len_eff = search_len_q;
    end
    repl_eff = (repl_len_q > MAX_L) ? MAX_L : repl_len_q;
  end

  for (genvar k = 0; k < MAX_WORD_BYTES; k++) begin : g_win
    assign win_new[k] = (fill_q[IDX_W-1:0] == IDX_W'(k)) ? in_byte_i : win_q[k];
    assign win_flat[8*k +: 8] = win_new[k];
    assign eq[k] = (win_new[k] == search_word_q[8*k +: 8]) || (CNT_W'(k) >= len_eff);
    if (k < MAX_WORD_BYTES - 1) begin : g_shift
      assign win_d[k] = full ? win_new[k+1] : win_new[k];
    end else begin : g_top
      assign win_d[k] = win_new[k];
    end
  end

  assign full  = (fill_q + CNT_W'(1)) == len_eff;
  assign match = &eq;

  always_comb begin
    cmd_o.last = in_last_i;
    cmd_data_o = win_flat;
    if (full && match) begin
      cmd_data_o  = repl_word_q[8*MAX_WORD_BYTES-1:0];
      cmd_o.count = repl_eff;
    end else if (full) begin
      cmd_o.count = in_last_i ? len_eff : CNT_W'(1);
    end else if (in_last_i) begin
      cmd_o.count = fill_q + CNT_W'(1);
    end else begin
      cmd_o.count = '0;
    end
  end

  assign push_o = accept && ((cmd_o.count != '0) || in_last_i);

  always_comb begin
    fill_d = fill_q;
    if (cfg_we_i && (sfr_cfg_e'(cfg_idx_i) == CFG_SEARCH_LEN)) begin
      fill_d = '0;
    end else if (accept) begin
      if (in_last_i || (full && match)) begin
        fill_d = '0;
      end else if (full) begin
        fill_d = len_eff - CNT_W'(1);
      end else begin
        fill_d = fill_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_word_q <= '0;
      search_len_q  <= 4'd1;
      repl_word_q   <= '0;
      repl_len_q    <= '0;
      fill_q        <= '0;
    end else begin
      fill_q <= fill_d;
      if (cfg_we_i) begin
        unique case (sfr_cfg_e'(cfg_idx_i))
          CFG_SEARCH_WORD: search_word_q <= cfg_data_i;
          CFG_SEARCH_LEN:  search_len_q  <= cfg_data_i[3:0];
          CFG_REPL_WORD:   repl_word_q   <= cfg_data_i;
          CFG_REPL_LEN:    repl_len_q    <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_q <= win_d;
    end
  end

  `SFR_ASSERT(a_fill_below_len, fill_q < len_eff, "window fill reached search length")
  `SFR_ASSERT(a_push_count, !push_o || (cmd_o.count <= MAX_L), "command count too large")
  `SFR_ASSERT(a_partial_silent, !(accept && !full && !in_last_i) || !push_o,
              "partial window produced a command")

endmodule

@@ hw/rtl/sfr_queue.sv @@
// ---------------------------------------------------------------------------
// Stream find-and-replace command queue
// Two-entry FIFO between classifier and serializer.
// ---------------------------------------------------------------------------
module sfr_queue
  import sfr_pkg::*;
#(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] head_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ hw/rtl/sfr_back.sv @@
// ---------------------------------------------------------------------------
// Stream find-and-replace serializer
// Loads one command at a time and sends its bytes one word per cycle unless
// stalled by m_axis_tready, or a bare end mark when a final command has none.
// ---------------------------------------------------------------------------
`include "stream_find_replace_macros.svh"

module sfr_back
  import sfr_pkg::*;
#(
  parameter int unsigned MAX_WORD_BYTES = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  sfr_cmd_t                    q_cmd_i,
  input  logic [8*MAX_WORD_BYTES-1:0] q_data_i,
  output logic                        q_pop_o,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,
  output logic                        m_axis_tuser,
  output logic                        m_axis_tlast
);

  localparam int unsigned IDX_W = (MAX_WORD_BYTES > 1) ? $clog2(MAX_WORD_BYTES) : 1;

  logic                        valid_q;
  sfr_cmd_t                    cmd_q;
  logic [8*MAX_WORD_BYTES-1:0] data_q;
  logic [IDX_W-1:0]            idx_q;
  logic                        final_word, done, load;

  assign final_word = (cmd_q.count == '0) || ((CNT_W'(idx_q) + CNT_W'(1)) == cmd_q.count);
  assign done       = valid_q && m_axis_tready && final_word;
  assign load       = q_valid_i && (!valid_q || done);
  assign q_pop_o    = load;

  assign m_axis_tvalid = valid_q;
  assign m_axis_tuser  = (cmd_q.count != '0);
  assign m_axis_tdata  = m_axis_tuser ? data_q[8*idx_q +: 8] : 8'd0;
  assign m_axis_tlast  = cmd_q.last && final_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
      cmd_q   <= '0;
    end else if (load) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
      cmd_q   <= q_cmd_i;
    end else if (done) begin
      valid_q <= 1'b0;
    end else if (valid_q && m_axis_tready) begin
      idx_q <= idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= q_data_i;
    end
  end

  `SFR_ASSERT(a_idx_in_range, !(valid_q && (cmd_q.count != '0)) || (CNT_W'(idx_q) < cmd_q.count),
              "byte index past command count")
  `SFR_ASSERT(a_bare_is_last, !(valid_q && (cmd_q.count == '0)) || cmd_q.last,
              "bare marker without end mark")
  `SFR_ASSERT_NEXT(a_idle_loads, !valid_q && q_valid_i, valid_q,
                   "pending command not loaded")

endmodule

@@ hw/rtl/stream_find_replace.sv @@
// ---------------------------------------------------------------------------
// Stream find-and-replace
// Rewrites a byte stream, replacing each non-overlapping search word with
// the replacement word.
//
//   channel   dir  handshake               payload
//   s_axis    in   tvalid/tready           tdata = in_byte, tlast = in_last
//   m_axis    out  tvalid/tready           tdata = out_byte, tuser = has_byte,
//                                          tlast = out_last
//   cfg       in   cfg_we_i (no wait)      cfg_idx_i, cfg_data_i
//
// One input word is taken per cycle while the two-entry command queue has room.
// The serializer sends one output word per cycle when m_axis_tready is high; a
// command of n bytes holds it until sent, so long replacements back-pressure
// the input through the queue; commands are registered there and in sfr_back.
// Reset empties the window, the queue and the output register.
// ---------------------------------------------------------------------------
module stream_find_replace
  import sfr_pkg::*;
#(
  parameter int unsigned MAX_WORD_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
  output logic        m_axis_tuser,  // [0] has_byte
  output logic        m_axis_tlast
);

  localparam int unsigned DATA_W = 8 * MAX_WORD_BYTES;
  localparam int unsigned ENTRY_W = DATA_W + $bits(sfr_cmd_t);

  logic              push, q_full, q_valid, q_pop;
  sfr_cmd_t          push_cmd, head_cmd;
  logic [DATA_W-1:0] push_data, head_data;
  logic [ENTRY_W-1:0] head;

  sfr_front #(
    .MAX_WORD_BYTES(MAX_WORD_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .cmd_data_o (push_data)
  );

  sfr_queue #(
    .WIDTH(ENTRY_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_cmd, push_data}),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (head)
  );

  assign head_cmd  = head[ENTRY_W-1:DATA_W];
  assign head_data = head[DATA_W-1:0];

  sfr_back #(
    .MAX_WORD_BYTES(MAX_WORD_BYTES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_cmd_i       (head_cmd),
    .q_data_i      (head_data),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
